>>> rtl/msht_pkg.sv
// ----------------------------------------------------------------------------
// msht_pkg
// Shared types and codes of the multiply-shift hash table core.
// ----------------------------------------------------------------------------
package msht_pkg;

   // actions
   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;

   // result status
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_PRESENT = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   // csr register indexes
   localparam int          CSR_INDEX_BITS = 4;
   localparam logic [3:0]  CSR_HASH_MULT  = 4'd0;
   localparam logic [3:0]  CSR_HASH_ADD   = 4'd1;
   localparam logic [31:0] HASH_MULT_RESET = 32'd2654435761;
   localparam logic [31:0] HASH_ADD_RESET  = 32'd0;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_value;
      logic [8:0]  entry_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_BUCKET,
      S_FILL,
      S_SCAN,
      S_DECIDE,
      S_SHIFT,
      S_RESULT
   } state_type;

endpackage

>>> rtl/msht_ram.sv
// ----------------------------------------------------------------------------
// msht_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module msht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/msht_hash.sv
// ----------------------------------------------------------------------------
// msht_hash
// Multiply-shift bucket hash: registered low product, then add and top bits.
// ----------------------------------------------------------------------------
module msht_hash #(
   parameter int BUCKET_BITS = 6
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic [31:0]            key,
   input  logic [31:0]            mult,
   input  logic [31:0]            add,
   output logic [BUCKET_BITS-1:0] bucket
);

   logic [31:0] prod_ff;
   logic [31:0] prod_in;
   logic [31:0] sum;

   // only the low word of the product matters (mod 2^32)
   assign prod_in = mult * key;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign sum    = prod_ff + add;
   assign bucket = sum[31 -: BUCKET_BITS];

endmodule

>>> rtl/multiply_shift_hash_table_core.sv
// ----------------------------------------------------------------------------
// multiply_shift_hash_table_core
// Bucketed key/value table addressed by a multiply-shift hash.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat per operation (lookup, insert, delete); rsp_*
//   returns one beat per request with status, found value and entry count.
//   A beat moves when valid is high and stall is low on that channel.
//   csr_* writes hash_mult (index 0) or hash_add (index 1); csr_ready is
//   always high, writes are meant to happen only while the core is idle.
// Operation:
//   One operation at a time. After accept the key is hashed through the
//   registered multiply, the bucket fill is read, and the bucket entries
//   are compared one per cycle through the single read port of the entry
//   RAM (at least one entry, at most BUCKET_DEPTH). On delete the entries
//   behind the hit are then moved down one per cycle; entries compared plus
//   entries moved is at most max(1, fill).
// Reset:
//   Synchronous, active high. After reset a clearing pass zeroes the
//   bucket fill RAM, one bucket per cycle, with req_stall high. The entry
//   RAM is not cleared.
// Stall:
//   The result sits in an output register; a new request is taken while it
//   waits. A finished result waits in S_RESULT until the register is free.
// ----------------------------------------------------------------------------
module multiply_shift_hash_table_core #(
   parameter int BUCKET_BITS  = 6,
   parameter int BUCKET_DEPTH = 4,
   parameter int VALUE_BITS   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  msht_pkg::req_type                   req_data,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output msht_pkg::rsp_type                   rsp_data,
   // csr write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [msht_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                         csr_wdata
);

   localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
   localparam int STORE_DEPTH = NUM_BUCKETS * BUCKET_DEPTH;
   localparam int ENTRY_ABITS = $clog2(STORE_DEPTH);
   localparam int FILL_BITS   = $clog2(BUCKET_DEPTH + 1);
   localparam int TOTAL_BITS  = $clog2(STORE_DEPTH + 1);
   localparam int ENTRY_W     = 32 + VALUE_BITS;

   // entry RAM address of slot s in bucket b
   function automatic logic [ENTRY_ABITS-1:0] entry_addr(
      input logic [BUCKET_BITS-1:0] b,
      input logic [FILL_BITS:0]     s
   );
      entry_addr = ENTRY_ABITS'(int'(b) * BUCKET_DEPTH + int'(s));
   endfunction

   msht_pkg::state_type state_ff, state_in;

   // config
   logic [31:0] hash_mult_ff, hash_add_ff;

   // item registers
   logic [1:0]             action_ff;
   logic [31:0]            key_ff;
   logic [VALUE_BITS-1:0]  value_ff;
   logic [63:0]            req_value_wide;
   logic [BUCKET_BITS-1:0] bucket_ff;
   logic [FILL_BITS-1:0]   fill_ff;
   logic [FILL_BITS-1:0]   idx_ff;
   logic [FILL_BITS-1:0]   slot_ff;
   logic                   found_ff;
   logic [VALUE_BITS-1:0]  fv_ff;
   logic [1:0]             status_ff, status_in;
   logic [TOTAL_BITS-1:0]  total_ff, total_in;
   logic [BUCKET_BITS-1:0] clr_ff;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   msht_pkg::rsp_type      rsp_ff;
   logic                   rsp_load;
   logic [63:0]            fv_wide;

   // hash
   logic                   hash_load;
   logic [BUCKET_BITS-1:0] hash_bucket;

   // fill RAM
   logic                   fill_we;
   logic [BUCKET_BITS-1:0] fill_waddr;
   logic [FILL_BITS-1:0]   fill_wdata;
   logic [FILL_BITS-1:0]   fill_rdata;

   // entry RAM
   logic                   entry_we;
   logic [ENTRY_ABITS-1:0] entry_waddr;
   logic [ENTRY_W-1:0]     entry_wdata;
   logic [FILL_BITS:0]     rd_slot;
   logic [ENTRY_ABITS-1:0] entry_raddr;
   logic [ENTRY_W-1:0]     entry_rdata;
   logic [31:0]            rd_key;
   logic [VALUE_BITS-1:0]  rd_value;

   // scan / shift conditions
   logic [FILL_BITS:0] idx_w, fill_w, slot_w;
   logic               scan_hit, scan_more, shift_more;
   logic               del_shift, ins_ok, room;

   msht_hash #(
      .BUCKET_BITS(BUCKET_BITS)
   ) u_hash (
      .clock (clock),
      .load  (hash_load),
      .key   (key_ff),
      .mult  (hash_mult_ff),
      .add   (hash_add_ff),
      .bucket(hash_bucket)
   );

   msht_ram #(
      .WIDTH(FILL_BITS),
      .DEPTH(NUM_BUCKETS)
   ) u_fill_ram (
      .clock  (clock),
      .wr_en  (fill_we),
      .wr_addr(fill_waddr),
      .wr_data(fill_wdata),
      .rd_addr(hash_bucket),
      .rd_data(fill_rdata)
   );

   msht_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(STORE_DEPTH)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (entry_we),
      .wr_addr(entry_waddr),
      .wr_data(entry_wdata),
      .rd_addr(entry_raddr),
      .rd_data(entry_rdata)
   );

   assign rd_key   = entry_rdata[ENTRY_W-1 -: 32];
   assign rd_value = entry_rdata[VALUE_BITS-1:0];

   assign idx_w  = {1'b0, idx_ff};
   assign fill_w = {1'b0, fill_ff};
   assign slot_w = {1'b0, slot_ff};

   assign scan_hit   = (idx_ff < fill_ff) && (rd_key == key_ff);
   assign scan_more  = !scan_hit && ((idx_w + 1'b1) < fill_w);
   assign shift_more = (idx_w + 2'd2) < fill_w;
   assign del_shift  = (action_ff == msht_pkg::ACT_DELETE) && found_ff
                       && ((slot_w + 1'b1) < fill_w);
   assign room       = fill_ff < FILL_BITS'(BUCKET_DEPTH);
   assign ins_ok     = (action_ff == msht_pkg::ACT_INSERT) && !found_ff && room;

   assign req_value_wide = {32'd0, req_data.value};

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msht_pkg::S_CLEAR:  if (clr_ff == '1) state_in = msht_pkg::S_IDLE;
         msht_pkg::S_IDLE:   if (req_valid) state_in = msht_pkg::S_HASH;
         msht_pkg::S_HASH:   state_in = msht_pkg::S_BUCKET;
         msht_pkg::S_BUCKET: state_in = msht_pkg::S_FILL;
         msht_pkg::S_FILL:   state_in = msht_pkg::S_SCAN;
         msht_pkg::S_SCAN:   if (!scan_more) state_in = msht_pkg::S_DECIDE;
         msht_pkg::S_DECIDE: begin
            state_in = del_shift ? msht_pkg::S_SHIFT : msht_pkg::S_RESULT;
         end
         msht_pkg::S_SHIFT:  if (!shift_more) state_in = msht_pkg::S_RESULT;
         msht_pkg::S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = msht_pkg::S_IDLE;
         end
         default:            state_in = msht_pkg::S_CLEAR;
      endcase
   end

   // ---------------- outputs / datapath control ----------------
   always_comb begin
      req_stall   = (state_ff != msht_pkg::S_IDLE);
      hash_load   = (state_ff == msht_pkg::S_HASH);
      fill_we     = 1'b0;
      fill_waddr  = bucket_ff;
      fill_wdata  = '0;
      entry_we    = 1'b0;
      entry_waddr = entry_addr(bucket_ff, fill_w);
      entry_wdata = {key_ff, value_ff};
      rd_slot     = '0;
      total_in    = total_ff;
      status_in   = status_ff;
      rsp_load    = 1'b0;
      case (state_ff)
         msht_pkg::S_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_ff;
         end
         msht_pkg::S_SCAN: begin
            rd_slot = idx_w + 1'b1;
         end
         msht_pkg::S_DECIDE: begin
            rd_slot   = slot_w + 1'b1;
            status_in = msht_pkg::ST_MISSING;
            case (action_ff)
               msht_pkg::ACT_LOOKUP: begin
                  if (found_ff) status_in = msht_pkg::ST_OK;
               end
               msht_pkg::ACT_INSERT: begin
                  if (found_ff) begin
                     status_in = msht_pkg::ST_PRESENT;
                  end else if (!room) begin
                     status_in = msht_pkg::ST_FULL;
                  end else begin
                     status_in  = msht_pkg::ST_OK;
                     entry_we   = 1'b1;
                     fill_we    = 1'b1;
                     fill_wdata = fill_ff + 1'b1;
                     total_in   = total_ff + 1'b1;
                  end
               end
               msht_pkg::ACT_DELETE: begin
                  if (found_ff) begin
                     status_in = msht_pkg::ST_OK;
                     // last entry of the bucket: nothing to move down
                     if (!del_shift) begin
                        fill_we    = 1'b1;
                        fill_wdata = fill_ff - 1'b1;
                        total_in   = total_ff - 1'b1;
                     end
                  end
               end
               default: status_in = msht_pkg::ST_MISSING;
            endcase
         end
         msht_pkg::S_SHIFT: begin
            rd_slot     = idx_w + 2'd2;
            entry_we    = 1'b1;
            entry_waddr = entry_addr(bucket_ff, idx_w);
            entry_wdata = entry_rdata;
            if (!shift_more) begin
               fill_we    = 1'b1;
               fill_wdata = fill_ff - 1'b1;
               total_in   = total_ff - 1'b1;
            end
         end
         msht_pkg::S_RESULT: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            rd_slot = '0;
         end
      endcase
      entry_raddr = entry_addr(bucket_ff, rd_slot);
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign fv_wide      = 64'(fv_ff);

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msht_pkg::S_CLEAR;
         clr_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hash_mult_ff <= msht_pkg::HASH_MULT_RESET;
         hash_add_ff  <= msht_pkg::HASH_ADD_RESET;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == msht_pkg::S_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               msht_pkg::CSR_HASH_MULT: hash_mult_ff <= csr_wdata;
               msht_pkg::CSR_HASH_ADD:  hash_add_ff  <= csr_wdata;
               default:                 hash_add_ff  <= hash_add_ff;
            endcase
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      case (state_ff)
         msht_pkg::S_IDLE: begin
            if (req_valid) begin
               action_ff <= req_data.action;
               key_ff    <= req_data.key;
               value_ff  <= req_value_wide[VALUE_BITS-1:0];
            end
         end
         msht_pkg::S_BUCKET: begin
            bucket_ff <= hash_bucket;
         end
         msht_pkg::S_FILL: begin
            fill_ff  <= fill_rdata;
            idx_ff   <= '0;
            found_ff <= 1'b0;
            fv_ff    <= '0;
         end
         msht_pkg::S_SCAN: begin
            if (scan_hit) begin
               found_ff <= 1'b1;
               slot_ff  <= idx_ff;
               fv_ff    <= rd_value;
            end
            if (scan_more) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         msht_pkg::S_DECIDE: begin
            idx_ff <= slot_ff;
            if (action_ff != msht_pkg::ACT_LOOKUP || ins_ok) begin
               fv_ff <= '0;
            end
         end
         msht_pkg::S_SHIFT: begin
            idx_ff <= idx_ff + 1'b1;
         end
         default: begin
            idx_ff <= idx_ff;
         end
      endcase
      if (rsp_load) begin
         rsp_ff.status      <= status_ff;
         rsp_ff.found_value <= fv_wide[31:0];
         rsp_ff.entry_count <= 9'(total_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule
